### rtl/sha256_pkg.sv
package sha256_pkg;

  localparam int unsigned NumHashWords = 8;
  localparam int unsigned NumBufWords  = 16;
  localparam int unsigned NumRounds    = 64;

  localparam logic [5:0] FillLastByte = 6'd63;
  localparam logic [5:0] FillLenStart = 6'd56;
  localparam logic [7:0] PadByte      = 8'h80;
  localparam logic [2:0] MaxBytes     = 3'd4;
  localparam logic [2:0] LastWordIdx  = 3'd7;
  localparam logic [5:0] LastRound    = 6'd63;

  localparam logic [31:0] InitHash [NumHashWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        end_of_message;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_PAD,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_e;

  typedef struct packed {
    logic      load;
    logic      push;
    byte_sel_e sel;
    logic [2:0] idx;
    logic      init_v;
    logic      round;
    logic [5:0] rnd;
    logic      add;
    logic      clear;
  } cmd_t;

  typedef struct packed {
    logic       fill63;
    logic       fill56;
    logic [2:0] cnt;
    logic       eom;
  } stat_t;

  function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

### rtl/sha256_dp.sv
module sha256_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sha256_pkg::in_t    in_data_i,
  input  sha256_pkg::cmd_t   cmd_i,
  output sha256_pkg::stat_t  stat_o,
  output sha256_pkg::out_t   out_data_o
);
  import sha256_pkg::*;

  logic [31:0] word_q;
  logic [2:0]  cnt_q;
  logic        eom_q;
  logic [5:0]  fill_q;
  logic [63:0] bytes_q;
  logic [31:0] hash_q [NumHashWords];
  logic [31:0] v_q    [NumHashWords];
  logic [31:0] buf_q  [NumBufWords];

  logic [2:0]  cnt_in;
  logic [7:0]  push_byte;
  logic [63:0] bit_len;
  logic [4:0]  shamt;
  logic [31:0] s0, s1, w_new, big_s0, big_s1, ch, maj, t1, t2;

  assign cnt_in  = (in_data_i.byte_count > MaxBytes) ? MaxBytes : in_data_i.byte_count;
  assign bit_len = {bytes_q[60:0], 3'b000};
  assign shamt   = {~fill_q[1:0], 3'b000};

  always_comb begin
    case (cmd_i.sel)
      SEL_DATA: push_byte = word_q[{~cmd_i.idx[1:0], 3'b000} +: 8];
      SEL_PAD:  push_byte = PadByte;
      SEL_LEN:  push_byte = bit_len[{~cmd_i.idx, 3'b000} +: 8];
      default:  push_byte = 8'h00;
    endcase
  end

  // message schedule runs in place over the block buffer
  assign s0    = rotr(buf_q[1], 7) ^ rotr(buf_q[1], 18) ^ (buf_q[1] >> 3);
  assign s1    = rotr(buf_q[14], 17) ^ rotr(buf_q[14], 19) ^ (buf_q[14] >> 10);
  assign w_new = s1 + buf_q[9] + s0 + buf_q[0];

  assign big_s1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
  assign big_s0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
  assign ch     = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj    = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1     = v_q[7] + big_s1 + ch + RoundK[cmd_i.rnd] + buf_q[0];
  assign t2     = big_s0 + maj;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      bytes_q <= '0;
      hash_q  <= InitHash;
    end else begin
      if (cmd_i.load) bytes_q <= bytes_q + 64'(cnt_in);
      if (cmd_i.push) fill_q <= fill_q + 6'd1;
      if (cmd_i.add) begin
        for (int i = 0; i < NumHashWords; i++) hash_q[i] <= hash_q[i] + v_q[i];
      end
      if (cmd_i.clear) begin
        hash_q  <= InitHash;
        bytes_q <= '0;
        fill_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      word_q <= in_data_i.data_word;
      cnt_q  <= cnt_in;
      eom_q  <= in_data_i.end_of_message;
    end
    if (cmd_i.round) begin
      for (int i = 0; i < NumBufWords - 1; i++) buf_q[i] <= buf_q[i + 1];
      buf_q[NumBufWords - 1] <= w_new;
    end else if (cmd_i.push) begin
      buf_q[fill_q[5:2]][shamt +: 8] <= push_byte;
    end
    if (cmd_i.init_v) begin
      v_q <= hash_q;
    end else if (cmd_i.round) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  assign stat_o.fill63 = (fill_q == FillLastByte);
  assign stat_o.fill56 = (fill_q == FillLenStart);
  assign stat_o.cnt    = cnt_q;
  assign stat_o.eom    = eom_q;

  assign out_data_o.digest_word = hash_q[cmd_i.idx];
  assign out_data_o.word_index  = cmd_i.idx;
  assign out_data_o.last_word   = (cmd_i.idx == LastWordIdx);

endmodule

### rtl/sha256_ctrl.sv
module sha256_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  sha256_pkg::stat_t  stat_i,
  output sha256_pkg::cmd_t   cmd_o
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BYTES,
    ST_PAD,
    ST_ZERO,
    ST_LEN,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_e;

  state_e     state_q, state_d, ret_q, ret_d;
  logic [2:0] k_q, k_d;
  logic [5:0] rnd_q, rnd_d;

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    k_d        = k_q;
    rnd_d      = rnd_q;
    cmd_o      = '0;
    cmd_o.sel  = SEL_ZERO;
    cmd_o.idx  = k_q;
    cmd_o.rnd  = rnd_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          k_d        = '0;
          state_d    = ST_BYTES;
        end
      end
      ST_BYTES: begin
        if (k_q == stat_i.cnt) begin
          k_d     = '0;
          state_d = stat_i.eom ? ST_PAD : ST_IDLE;
        end else begin
          cmd_o.push = 1'b1;
          cmd_o.sel  = SEL_DATA;
          k_d        = k_q + 3'd1;
          if (stat_i.fill63) begin
            cmd_o.init_v = 1'b1;
            ret_d        = ST_BYTES;
            rnd_d        = '0;
            state_d      = ST_ROUND;
          end
        end
      end
      ST_PAD: begin
        cmd_o.push = 1'b1;
        cmd_o.sel  = SEL_PAD;
        state_d    = ST_ZERO;
        if (stat_i.fill63) begin
          cmd_o.init_v = 1'b1;
          ret_d        = ST_ZERO;
          rnd_d        = '0;
          state_d      = ST_ROUND;
        end
      end
      ST_ZERO: begin
        if (stat_i.fill56) begin
          k_d     = '0;
          state_d = ST_LEN;
        end else begin
          cmd_o.push = 1'b1;
          cmd_o.sel  = SEL_ZERO;
          if (stat_i.fill63) begin
            cmd_o.init_v = 1'b1;
            ret_d        = ST_ZERO;
            rnd_d        = '0;
            state_d      = ST_ROUND;
          end
        end
      end
      ST_LEN: begin
        cmd_o.push = 1'b1;
        cmd_o.sel  = SEL_LEN;
        k_d        = k_q + 3'd1;
        if (k_q == LastWordIdx) begin
          cmd_o.init_v = 1'b1;
          ret_d        = ST_OUT;
          rnd_d        = '0;
          k_d          = '0;
          state_d      = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        rnd_d       = rnd_q + 6'd1;
        if (rnd_q == LastRound) state_d = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = ret_q;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          k_d = k_q + 3'd1;
          if (k_q == LastWordIdx) begin
            cmd_o.clear = 1'b1;
            k_d         = '0;
            state_d     = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      k_q     <= '0;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      k_q     <= k_d;
      rnd_q   <= rnd_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

endmodule

### rtl/sha256_message_hasher.sv
// sha-256 message hasher
// input channel (in_valid_i / in_stall_o / in_data_i): one item per accepted
// handshake, carrying a big-endian word with 0 to 4 leading valid bytes and an
// end-of-message flag; only the final item of a message may be partial, and
// byte counts above four count as four
// output channel (out_valid_o / out_stall_i / out_data_o): after an item with
// end of message, the eight digest words come out in order, index 0 first,
// last_word set on index 7
// sequence: the byte loader takes an item and pushes its bytes into the block
// buffer; every 64 bytes start the round unit (one round per cycle) and the
// hash update; the end of message pushes the pad byte, zero bytes up to the
// length field and the 8 length bytes, runs the round unit and hash update for
// each block that the padding completes, then gives the 8 digest words at one
// per cycle when the receiver does not stall
// the block takes one item at a time: in_stall_o is high while an item is in
// the loader, the round unit or the digest output
// a stalled output word holds until taken; the next message starts after the
// last digest word is taken
// reset loads the initial hash values and clears the fill and length counters
module sha256_message_hasher (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sha256_pkg::in_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sha256_pkg::out_t  out_data_o
);
  import sha256_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: byte loading, padding, rounds and digest readout
  sha256_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // block buffer, schedule, round unit and running hash
  sha256_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule
